// ===== design/gcmi_pkg.sv =====
// shared types, constants and helpers for the g-code motion command interpreter
package gcmi_pkg;

   localparam int unsigned X_STEPS_MM    = 80;
   localparam int unsigned Y_STEPS_MM    = 80;
   localparam int unsigned Z_STEPS_MM    = 400;
   localparam int unsigned FRACTION_BITS = 16;

   // opcodes
   localparam logic [3:0] OP_G0    = 4'd0;
   localparam logic [3:0] OP_G1    = 4'd1;
   localparam logic [3:0] OP_G28   = 4'd2;
   localparam logic [3:0] OP_G90   = 4'd3;
   localparam logic [3:0] OP_G91   = 4'd4;
   localparam logic [3:0] OP_G92   = 4'd5;
   localparam logic [3:0] OP_G92_1 = 4'd6;
   localparam logic [3:0] OP_M110  = 4'd7;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_LINE    = 3'd1;
   localparam logic [2:0] ST_ARG     = 3'd2;
   localparam logic [2:0] ST_COMMAND = 3'd3;
   localparam logic [2:0] ST_SCAN    = 3'd4;

   // register indexes
   localparam logic [2:0] REG_X_MIN = 3'd0;
   localparam logic [2:0] REG_X_MAX = 3'd1;
   localparam logic [2:0] REG_Y_MIN = 3'd2;
   localparam logic [2:0] REG_Y_MAX = 3'd3;
   localparam logic [2:0] REG_Z_MIN = 3'd4;
   localparam logic [2:0] REG_Z_MAX = 3'd5;
   localparam logic [2:0] REG_FEED  = 3'd6;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [3:0]         opcode;
      logic               scan_error;
      logic               has_line_number;
      logic [31:0]        line_number;
      logic               line_number_whole;
      logic [3:0]         arg_mask;
      logic               unknown_arg;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
      logic signed [31:0] z_value;
      logic [15:0]        feed_value;
   } req_type;

   // classified line passed from front to back
   typedef struct packed {
      logic [3:0]         opcode;
      logic               scan_error;
      logic               has_line_number;
      logic [31:0]        line_number;
      logic               line_number_whole;
      logic               arg_bad;
      logic               op_unknown;
      logic [3:0]         arg_mask;
      logic signed [47:0] x_steps;
      logic signed [47:0] y_steps;
      logic signed [47:0] z_steps;
      logic [15:0]        feed_value;
   } cmd_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [31:0]        echo_line_number;
      logic               move_valid;
      logic signed [31:0] move_from_x;
      logic signed [31:0] move_from_y;
      logic signed [31:0] move_from_z;
      logic signed [31:0] move_to_x;
      logic signed [31:0] move_to_y;
      logic signed [31:0] move_to_z;
      logic [15:0]        move_feed;
      logic [2:0]         home_mask;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > 50'sd2147483647) r = 32'sh7fffffff;
      else if (v < -50'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // trunc toward zero of product / 2^FRACTION_BITS
   function automatic logic signed [47:0] scale_down(input logic signed [47:0] p);
      logic signed [47:0] adj;
      adj = p;
      if (p < 0) adj = p + ((48'sd1 <<< FRACTION_BITS) - 48'sd1);
      return adj >>> FRACTION_BITS;
   endfunction

endpackage

// ===== design/gcmi_front.sv =====
// front end: argument check, classification and mm to steps conversion
module gcmi_front
   import gcmi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_req,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   logic    stage_valid_ff, stage_valid_in;
   req_type stage_ff;
   logic signed [47:0] px_ff, py_ff, pz_ff;
   logic    stage_go;
   logic    arg_bad;
   logic    op_unknown;

   assign stage_go = !out_valid || out_ready;
   assign in_ready = !stage_valid_ff || stage_go;

   // stage one: products, registered
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (in_valid && in_ready) begin
         stage_ff <= in_req;
         px_ff <= 48'(in_req.x_value) * 48'(X_STEPS_MM);
         py_ff <= 48'(in_req.y_value) * 48'(Y_STEPS_MM);
         pz_ff <= 48'(in_req.z_value) * 48'(Z_STEPS_MM);
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff && !stage_go;
      if (in_valid && in_ready) stage_valid_in = 1'b1;
   end

   always_comb begin
      op_unknown = 1'b0;
      case (stage_ff.opcode)
         OP_G0, OP_G1: arg_bad = stage_ff.unknown_arg;
         OP_G28, OP_G92: arg_bad = stage_ff.unknown_arg || stage_ff.arg_mask[3];
         OP_G90, OP_G91, OP_G92_1, OP_M110:
            arg_bad = stage_ff.unknown_arg || (stage_ff.arg_mask != 4'd0);
         default: begin
            arg_bad = 1'b0;
            op_unknown = 1'b1;
         end
      endcase
   end

   // stage two: output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (stage_go) begin
         out_valid <= stage_valid_ff;
      end
      if (stage_go && stage_valid_ff) begin
         out_cmd.opcode            <= stage_ff.opcode;
         out_cmd.scan_error        <= stage_ff.scan_error;
         out_cmd.has_line_number   <= stage_ff.has_line_number;
         out_cmd.line_number       <= stage_ff.line_number;
         out_cmd.line_number_whole <= stage_ff.line_number_whole;
         out_cmd.arg_bad           <= arg_bad;
         out_cmd.op_unknown        <= op_unknown;
         out_cmd.arg_mask          <= stage_ff.arg_mask;
         out_cmd.x_steps           <= scale_down(px_ff);
         out_cmd.y_steps           <= scale_down(py_ff);
         out_cmd.z_steps           <= scale_down(pz_ff);
         out_cmd.feed_value        <= stage_ff.feed_value;
      end
   end

endmodule

// ===== design/gcmi_queue.sv =====
// short fifo between front and back
module gcmi_queue
   import gcmi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   cmd_type entry_ff [QUEUE_DEPTH];
   logic [$clog2(QUEUE_DEPTH)-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [$clog2(QUEUE_DEPTH):0]   count_ff;
   logic push, pop;

   assign in_ready  = count_ff != ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
      if (push) entry_ff[wr_ptr_ff] <= in_cmd;
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH))
      else $error("queue count overflow");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count not decremented");
   a_push_moves: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count not incremented");
`endif

endmodule

// ===== design/gcmi_back.sv =====
// back end: line check, state update and result register
module gcmi_back
   import gcmi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  cmd_type            in_cmd,
   output logic               out_valid,
   input  logic               out_ready,
   output rsp_type            out_rsp,
   input  logic signed [31:0] lim_min [3],
   input  logic signed [31:0] lim_max [3],
   input  logic               feed_load,
   input  logic [15:0]        feed_load_value
);

   logic signed [31:0] path_ff [3];
   logic signed [31:0] offset_ff [3];
   logic [15:0] feed_ff;
   logic        abs_ff;
   logic [31:0] prev_ff;
   logic [31:0] rep_ff;
   logic        take;
   logic [2:0]  status;
   logic [31:0] rep_next;
   logic signed [47:0] steps [3];
   logic signed [31:0] dest [3];
   logic signed [31:0] ofs_new [3];
   logic signed [31:0] d0 [3];
   logic signed [31:0] base;
   logic ok;
   rsp_type rsp_next;

   assign in_ready = !out_valid || out_ready;
   assign take = in_valid && in_ready;
   assign steps[0] = in_cmd.x_steps;
   assign steps[1] = in_cmd.y_steps;
   assign steps[2] = in_cmd.z_steps;

   always_comb begin
      status = in_cmd.scan_error ? ST_SCAN : ST_OK;
      rep_next = rep_ff;
      if (in_cmd.has_line_number) begin
         rep_next = in_cmd.line_number;
         if (in_cmd.opcode == OP_M110) begin
            if (in_cmd.arg_mask != 4'd0 || in_cmd.arg_bad) status = ST_ARG;
         end else if (((prev_ff != 32'd0) && (in_cmd.line_number != prev_ff + 32'd1))
                      || !in_cmd.line_number_whole) begin
            if (status == ST_OK) status = ST_LINE;
         end
      end
      // m110 arguments only matter on a numbered line, checked above
      if (status == ST_OK) begin
         if (in_cmd.op_unknown) status = ST_COMMAND;
         else if (in_cmd.arg_bad && in_cmd.opcode != OP_M110) status = ST_ARG;
      end
      ok = status == ST_OK;
      for (int i = 0; i < 3; i++) begin
         base = abs_ff ? offset_ff[i] : path_ff[i];
         d0[i] = path_ff[i];
         if (in_cmd.arg_mask[i])
            d0[i] = sat32(50'(steps[i]) + 50'(base));
         if (d0[i] < lim_min[i]) dest[i] = sat32(50'(lim_min[i]) + 50'sd1);
         else if (d0[i] > lim_max[i]) dest[i] = sat32(50'(lim_max[i]) - 50'sd1);
         else dest[i] = d0[i];
         ofs_new[i] = sat32(50'(path_ff[i]) - 50'(steps[i]));
      end
      rsp_next = '0;
      rsp_next.status = status;
      rsp_next.echo_line_number = rep_next;
      if (ok) begin
         case (in_cmd.opcode)
            OP_G0, OP_G1: begin
               rsp_next.move_valid  = 1'b1;
               rsp_next.move_from_x = path_ff[0];
               rsp_next.move_from_y = path_ff[1];
               rsp_next.move_from_z = path_ff[2];
               rsp_next.move_to_x   = dest[0];
               rsp_next.move_to_y   = dest[1];
               rsp_next.move_to_z   = dest[2];
               rsp_next.move_feed   = in_cmd.arg_mask[3] ? in_cmd.feed_value : feed_ff;
            end
            OP_G28: begin
               rsp_next.home_mask = (in_cmd.arg_mask[2:0] != 3'd0) ?
                                    in_cmd.arg_mask[2:0] : 3'd7;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            path_ff[i]   <= '0;
            offset_ff[i] <= '0;
         end
         feed_ff <= 16'd1000;
         abs_ff  <= 1'b1;
         prev_ff <= '0;
         rep_ff  <= '0;
      end else begin
         if (feed_load) feed_ff <= feed_load_value;
         if (take) begin
            out_valid <= 1'b1;
            rep_ff <= rep_next;
            out_rsp <= rsp_next;
            if (ok && in_cmd.line_number != 32'd0 && in_cmd.has_line_number)
               prev_ff <= in_cmd.line_number;
            if (ok) begin
               case (in_cmd.opcode)
                  OP_G0, OP_G1: begin
                     if (in_cmd.arg_mask[3]) feed_ff <= in_cmd.feed_value;
                     for (int i = 0; i < 3; i++) path_ff[i] <= dest[i];
                  end
                  OP_G28: begin
                     for (int i = 0; i < 3; i++) path_ff[i] <= '0;
                  end
                  OP_G90: abs_ff <= 1'b1;
                  OP_G91: abs_ff <= 1'b0;
                  OP_G92: begin
                     for (int i = 0; i < 3; i++) begin
                        if (in_cmd.arg_mask[2:0] == 3'd0) offset_ff[i] <= path_ff[i];
                        else if (in_cmd.arg_mask[i]) offset_ff[i] <= ofs_new[i];
                     end
                  end
                  OP_G92_1: for (int i = 0; i < 3; i++) offset_ff[i] <= '0;
                  default: ;
               endcase
            end
         end else if (out_ready) begin
            out_valid <= 1'b0;
         end
      end
   end

`ifndef ASSERT_OFF
   a_move_only_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_rsp.move_valid |-> out_rsp.status == ST_OK)
      else $error("move with error status");
   a_home_only_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_rsp.home_mask != 3'd0 |-> out_rsp.status == ST_OK)
      else $error("homing with error status");
   a_not_both: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !(out_rsp.move_valid && out_rsp.home_mask != 3'd0))
      else $error("move and homing together");
`endif

endmodule

// ===== design/gcode_motion_command_interpreter.sv =====
// top level of the g-code motion command interpreter
//
// usage:
//  - req_ channel: one parsed g-code line per transfer (valid/ready)
//  - rsp_ channel: exactly one result per line, in order: status, echoed
//    line number, optional motion vector and homing mask
//  - csr_ port: apb-style, axis limits at 0x00..0x14 and default feed at
//    0x18; writing the default feed also loads the current feed rate
// path: from request transfer to result valid (front stage one:
//  multiply; front stage two: scale and classify; one queue slot;
//  back end result register)
// throughput: one line per cycle when the receiver keeps up; the state
//  update in the back end is the loop that sets this
// reset: synchronous; positions and offsets clear, absolute mode, feed
//  1000, limits 0 and 100000, line counters zero
// stall: a stalled receiver holds the result; the queue and front stages
//  fill and req_ready drops only once all of them are full
module gcode_motion_command_interpreter
   import gcmi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_opcode,
   input  logic               req_scan_error,
   input  logic               req_has_line_number,
   input  logic [31:0]        req_line_number,
   input  logic               req_line_number_whole,
   input  logic [3:0]         req_arg_mask,
   input  logic               req_unknown_arg,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   input  logic signed [31:0] req_z_value,
   input  logic [15:0]        req_feed_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_echo_line_number,
   output logic               rsp_move_valid,
   output logic signed [31:0] rsp_move_from_x,
   output logic signed [31:0] rsp_move_from_y,
   output logic signed [31:0] rsp_move_from_z,
   output logic signed [31:0] rsp_move_to_x,
   output logic signed [31:0] rsp_move_to_y,
   output logic signed [31:0] rsp_move_to_z,
   output logic [15:0]        rsp_move_feed,
   output logic [2:0]         rsp_home_mask,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   req_type req;
   cmd_type front_cmd, queue_cmd;
   rsp_type rsp;
   logic front_valid, front_ready, queue_valid, queue_ready;
   logic signed [31:0] min_ff [3];
   logic signed [31:0] max_ff [3];
   logic [15:0] dfeed_ff;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign req = '{req_opcode, req_scan_error, req_has_line_number, req_line_number,
                  req_line_number_whole, req_arg_mask, req_unknown_arg,
                  req_x_value, req_y_value, req_z_value, req_feed_value};

   // configuration registers
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            min_ff[i] <= '0;
            max_ff[i] <= 32'sd100000;
         end
         dfeed_ff <= 16'd1000;
      end else if (wr_en) begin
         case (reg_idx)
            REG_X_MIN: min_ff[0] <= pwdata;
            REG_X_MAX: max_ff[0] <= pwdata;
            REG_Y_MIN: min_ff[1] <= pwdata;
            REG_Y_MAX: max_ff[1] <= pwdata;
            REG_Z_MIN: min_ff[2] <= pwdata;
            REG_Z_MAX: max_ff[2] <= pwdata;
            REG_FEED:  dfeed_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_X_MIN: prdata = min_ff[0];
         REG_X_MAX: prdata = max_ff[0];
         REG_Y_MIN: prdata = min_ff[1];
         REG_Y_MAX: prdata = max_ff[1];
         REG_Z_MIN: prdata = min_ff[2];
         REG_Z_MAX: prdata = max_ff[2];
         REG_FEED:  prdata = {16'd0, dfeed_ff};
         default:   prdata = '0;
      endcase
   end

   gcmi_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_req(req),
      .out_valid(front_valid), .out_ready(front_ready), .out_cmd(front_cmd)
   );

   gcmi_queue u_queue (
      .clock, .reset,
      .in_valid(front_valid), .in_ready(front_ready), .in_cmd(front_cmd),
      .out_valid(queue_valid), .out_ready(queue_ready), .out_cmd(queue_cmd)
   );

   gcmi_back u_back (
      .clock, .reset,
      .in_valid(queue_valid), .in_ready(queue_ready), .in_cmd(queue_cmd),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_rsp(rsp),
      .lim_min(min_ff), .lim_max(max_ff),
      .feed_load(wr_en && reg_idx == REG_FEED), .feed_load_value(pwdata[15:0])
   );

   assign rsp_status           = rsp.status;
   assign rsp_echo_line_number = rsp.echo_line_number;
   assign rsp_move_valid       = rsp.move_valid;
   assign rsp_move_from_x      = rsp.move_from_x;
   assign rsp_move_from_y      = rsp.move_from_y;
   assign rsp_move_from_z      = rsp.move_from_z;
   assign rsp_move_to_x        = rsp.move_to_x;
   assign rsp_move_to_y        = rsp.move_to_y;
   assign rsp_move_to_z        = rsp.move_to_z;
   assign rsp_move_feed        = rsp.move_feed;
   assign rsp_home_mask        = rsp.home_mask;

endmodule
